>>> rtl/core/assert_macros.svh
// Assertion macros shared by the capture RTL.
// Include where concurrent checks are written; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define IPWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define IPWC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `IPWC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/ipwc_pkg.sv
// Shared constants for the IR pulse width capture block.
// No dependencies; used by ipwc_store and ir_pulse_width_capture_top.
`timescale 1ns / 1ps

package ipwc_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int PULSE_W          = 16;
    localparam int TIME_W           = 32;
    localparam int CAP_W            = 7;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;

    localparam logic [TIME_W-1:0]  TIMEOUT_RST  = 32'd20000;
    localparam logic [PULSE_W-1:0] EXCESS_RST   = 16'd0;
    localparam logic [CAP_W-1:0]   CAPACITY_RST = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXCESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd2;

endpackage

>>> rtl/core/ipwc_store.sv
// Pulse buffer: single-port-write, single-port-read RAM, registered read.
// Depends on ipwc_pkg for default widths.
`timescale 1ns / 1ps

module ipwc_store #(
    parameter int DEPTH  = ipwc_pkg::BUFFER_DEPTH_DEF,
    parameter int WIDTH  = ipwc_pkg::PULSE_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/ir_pulse_width_capture_top.sv
// IR pulse width capture, top level: edge/tick front end, frame flush, output stage.
// Depends on ipwc_pkg, ipwc_store and assert_macros.svh.
`timescale 1ns / 1ps

// Turns the edges of an IR receiver line into signed microsecond durations
// (marks positive, spaces negative, each corrected by excess_us) held in a
// BUFFER_DEPTH-entry RAM. Edge transactions (cmd 0) and tick transactions
// (cmd 1) can arrive every cycle while no flush is in progress. A tick that
// finds timeout_us of silence after a good frame starts a flush: the block
// then reads the RAM one entry per cycle, unless the output stalls, through
// its single read port and takes no input until every read is issued; the
// first pulse goes through the RAM read register and the output register.
// Pulses leave through a registered output with a one-entry skid (the RAM
// read register), so the front end opens again while the last pulses still
// wait for o_out_ready. The RAM is not cleared after reset; only entries
// written in the current frame are ever read. Configuration writes are
// always taken (o_cfg_ready is high) and should be issued only while the
// block is idle.

`include "assert_macros.svh"

module ir_pulse_width_capture_top #(
    parameter int BUFFER_DEPTH = ipwc_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cmd,
    input  logic [ipwc_pkg::TIME_W-1:0]      i_now_us,
    input  logic                             i_pin_level,
    // pulse output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [ipwc_pkg::PULSE_W-1:0] o_pulse,
    output logic                             o_last,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ipwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ipwc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int POS_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int PW     = ipwc_pkg::PULSE_W;
    localparam int TW     = ipwc_pkg::TIME_W;
    localparam int CW     = ipwc_pkg::CAP_W;

    localparam logic [POS_W-1:0] POS_FULL  = POS_W'(BUFFER_DEPTH);
    localparam logic [CW-1:0]    DEPTH_CAP = CW'(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_MARK     = 2'd1,
        MODE_SPACE    = 2'd2,
        MODE_OVERFLOW = 2'd3
    } t_mode;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    // configuration
    logic [PW-1:0]    r_excess;
    logic [TW-1:0]    r_timeout;
    logic [CW-1:0]    r_capacity;

    // capture state
    t_mode            r_mode,      n_mode;
    logic [TW-1:0]    r_prev_time, n_prev_time;
    logic [POS_W-1:0] r_pos,       n_pos;

    // flush sequencer and output stage
    t_state           r_state,     n_state;
    logic [POS_W-1:0] r_rd_addr,   n_rd_addr;
    logic [POS_W-1:0] r_flush_n,   n_flush_n;
    logic             r_q_valid,   n_q_valid;
    logic             r_q_last,    n_q_last;
    logic             r_out_valid, n_out_valid;
    logic [PW-1:0]    r_out_pulse, n_out_pulse;
    logic             r_out_last,  n_out_last;

    logic             in_acc;
    logic [TW-1:0]    elapsed;
    logic [PW-1:0]    mark_val;
    logic [PW-1:0]    space_val;
    logic [CW-1:0]    eff_cap;
    logic             do_store;
    logic [POS_W-1:0] pos_after;
    logic             timed_out;
    logic             load_out;
    logic             rd_en;
    logic [PW-1:0]    rd_data;

    assign in_acc    = i_in_valid && o_in_ready;
    assign elapsed   = i_now_us - r_prev_time;
    // only the low 16 bits survive, so the correction is done at that width
    assign mark_val  = elapsed[PW-1:0] - r_excess;
    assign space_val = PW'(0) - (elapsed[PW-1:0] + r_excess);
    assign eff_cap   = (r_capacity > DEPTH_CAP) ? DEPTH_CAP : r_capacity;
    assign do_store  = in_acc && !i_cmd && (r_pos < POS_FULL) &&
                       ((r_mode == MODE_MARK) || (r_mode == MODE_SPACE));
    assign pos_after = do_store ? (r_pos + POS_W'(1)) : r_pos;
    assign timed_out = (r_mode != MODE_IDLE) && (elapsed >= r_timeout);

    // RAM read register acts as the skid entry behind the output register
    assign load_out  = r_q_valid && (!r_out_valid || i_out_ready);
    assign rd_en     = (r_state == ST_FLUSH) && (!r_q_valid || load_out);

    ipwc_store #(
        .DEPTH  (BUFFER_DEPTH),
        .WIDTH  (PW),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (do_store),
        .i_wr_addr (r_pos[ADDR_W-1:0]),
        .i_wr_data ((r_mode == MODE_MARK) ? mark_val : space_val),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_mode      = r_mode;
        n_prev_time = r_prev_time;
        n_pos       = r_pos;
        n_state     = r_state;
        n_rd_addr   = r_rd_addr;
        n_flush_n   = r_flush_n;
        n_q_valid   = r_q_valid;
        n_q_last    = r_q_last;
        n_out_valid = r_out_valid;
        n_out_pulse = r_out_pulse;
        n_out_last  = r_out_last;

        if (in_acc) begin
            if (!i_cmd) begin
                // edge: close the running interval, pick the next mode
                n_pos       = pos_after;
                n_prev_time = i_now_us;
                if (CW'(pos_after) >= eff_cap) begin
                    n_mode = MODE_OVERFLOW;
                end else if (i_pin_level) begin
                    n_mode = MODE_SPACE;
                end else begin
                    n_mode = MODE_MARK;
                end
            end else if (timed_out) begin
                n_mode = MODE_IDLE;
                n_pos  = '0;
                if ((r_pos != '0) && (r_mode != MODE_OVERFLOW)) begin
                    n_state   = ST_FLUSH;
                    n_flush_n = r_pos;
                    n_rd_addr = '0;
                end
            end
        end

        if (rd_en) begin
            n_rd_addr = r_rd_addr + POS_W'(1);
            n_q_last  = (r_rd_addr == (r_flush_n - POS_W'(1)));
            if (r_rd_addr == (r_flush_n - POS_W'(1))) begin
                n_state = ST_RUN;
            end
        end

        if (rd_en) begin
            n_q_valid = 1'b1;
        end else if (load_out) begin
            n_q_valid = 1'b0;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_pulse = rd_data;
            n_out_last  = r_q_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_prev_time <= '0;
            r_pos       <= '0;
            r_state     <= ST_RUN;
            r_rd_addr   <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_prev_time <= n_prev_time;
            r_pos       <= n_pos;
            r_state     <= n_state;
            r_rd_addr   <= n_rd_addr;
            r_q_valid   <= n_q_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_flush_n   <= n_flush_n;
        r_q_last    <= n_q_last;
        r_out_pulse <= n_out_pulse;
        r_out_last  <= n_out_last;
    end

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excess   <= ipwc_pkg::EXCESS_RST;
            r_timeout  <= ipwc_pkg::TIMEOUT_RST;
            r_capacity <= ipwc_pkg::CAPACITY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ipwc_pkg::REG_EXCESS:   r_excess   <= i_cfg_data[PW-1:0];
                ipwc_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data[TW-1:0];
                ipwc_pkg::REG_CAPACITY: r_capacity <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_RUN);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_pulse     = r_out_pulse;
    assign o_last      = r_out_last;

    `IPWC_ASSERT(a_pos_bound, i_clk, i_rst_n, r_pos <= POS_FULL, "position beyond buffer depth")
    `IPWC_ASSERT(a_flush_idle, i_clk, i_rst_n, (r_state == ST_FLUSH) |-> (r_mode == MODE_IDLE), "flush while capture mode not idle")
    `IPWC_ASSERT(a_rd_fills_q, i_clk, i_rst_n, rd_en |=> r_q_valid, "RAM read did not fill the skid entry")
    `IPWC_ASSERT_NEVER(a_rd_range, i_clk, i_rst_n, rd_en && (r_rd_addr >= r_flush_n), "read past end of frame")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for ir_pulse_width_capture_top: directed and random edge/tick traffic,
// pulses checked in order against a frame model kept in a small scoreboard class.
// Depends on ipwc_pkg and the capture RTL; needs no other files.

module tb;

    localparam int DEPTH      = ipwc_pkg::BUFFER_DEPTH_DEF;
    localparam int PULSE_W    = ipwc_pkg::PULSE_W;
    localparam int TIME_W     = ipwc_pkg::TIME_W;
    localparam int CAP_W      = ipwc_pkg::CAP_W;
    localparam int CFG_IDX_W  = ipwc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ipwc_pkg::CFG_DATA_W;

    // item commands
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES   = 8;     // quiet time before a register write
    localparam int DRAIN_CYCLES    = 20;    // quiet time before the verdict
    localparam int HOLD_CYCLES     = 400;   // long output stall, fills the block
    localparam int ITEMS_PER_PHASE = 68;
    localparam int PHASES          = 6;
    localparam int LIMIT_NS        = 20_000_000;

    typedef enum logic [1:0] {
        CAP_IDLE,
        CAP_MARK,
        CAP_SPACE,
        CAP_OVERFLOW
    } t_capture_mode;

    typedef struct {
        logic signed [PULSE_W-1:0] pulse;
        logic                      last;
    } t_pulse;

    // Frame model: mirrors the capture buffer and holds the pulses still owed
    // by the block, oldest first.
    class t_frame_tracker;
        logic signed [PULSE_W-1:0] excess;
        logic [TIME_W-1:0]         timeout;
        logic [CAP_W-1:0]          capacity;
        t_capture_mode             mode;
        logic [TIME_W-1:0]         prev_time;
        int unsigned               fill;
        logic [PULSE_W-1:0]        entries [DEPTH];
        t_pulse                    pulses_due [$];
        int unsigned               errors;

        function new();
            excess    = ipwc_pkg::EXCESS_RST;
            timeout   = ipwc_pkg::TIMEOUT_RST;
            capacity  = ipwc_pkg::CAPACITY_RST;
            mode      = CAP_IDLE;
            prev_time = '0;
            fill      = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                ipwc_pkg::REG_EXCESS:   excess   = data[PULSE_W-1:0];
                ipwc_pkg::REG_TIMEOUT:  timeout  = data[TIME_W-1:0];
                ipwc_pkg::REG_CAPACITY: capacity = data[CAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the transaction did something (any edge, or a tick
        // that closed a frame).
        function bit capture_item(logic cmd, logic [TIME_W-1:0] now, logic pin);
            logic [TIME_W-1:0] elapsed;
            logic [TIME_W-1:0] ex_wide;
            logic [TIME_W-1:0] value;
            int unsigned       limit;
            t_pulse            p;
            elapsed = now - prev_time;
            ex_wide = {{(TIME_W-PULSE_W){excess[PULSE_W-1]}}, excess};
            if (cmd == CMD_EDGE) begin
                if (mode == CAP_MARK) begin
                    value = elapsed - ex_wide;
                end else begin
                    value = 32'd0 - (elapsed + ex_wide);
                end
                if ((mode == CAP_MARK || mode == CAP_SPACE) && fill < DEPTH) begin
                    entries[fill] = value[PULSE_W-1:0];
                    fill++;
                end
                limit = (capacity > DEPTH) ? DEPTH : capacity;
                mode = (fill >= limit) ? CAP_OVERFLOW : (pin ? CAP_SPACE : CAP_MARK);
                prev_time = now;
                return 1'b1;
            end
            if (mode == CAP_IDLE || elapsed < timeout) begin
                return 1'b0;
            end
            if (fill > 0 && mode != CAP_OVERFLOW) begin
                for (int i = 0; i < fill; i++) begin
                    p.pulse = entries[i];
                    p.last  = (i == fill - 1);
                    pulses_due.push_back(p);
                end
            end
            mode = CAP_IDLE;
            fill = 0;
            return 1'b1;
        endfunction

        function void match_pulse(logic signed [PULSE_W-1:0] pulse, logic last);
            t_pulse want;
            if (pulses_due.size() == 0) begin
                $error("pulse %0d (last %0b) arrived with nothing due", pulse, last);
                errors++;
                return;
            end
            want = pulses_due.pop_front();
            if (pulse !== want.pulse) begin
                $error("pulse: expected %0d, actual %0d", want.pulse, pulse);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals, every input known from time zero
    // ------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic                      i_cmd       = CMD_EDGE;
    logic [TIME_W-1:0]         i_now_us    = '0;
    logic                      i_pin_level = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [PULSE_W-1:0] o_pulse;
    logic                      o_last;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data  = '0;

    t_frame_tracker frames;

    int          tx_idle_pct  = 0;   // chance per cycle that the sender holds back
    int          rx_idle_pct  = 0;   // chance per cycle that the receiver stalls
    int unsigned live_items   = 0;   // transactions that were not simply ignored
    bit          hold_armed   = 1'b0;
    bit          hold_started = 1'b0;
    int          hold_left    = 0;

    ir_pulse_width_capture_top #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_now_us    (i_now_us),
        .i_pin_level (i_pin_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pulse     (o_pulse),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: random stalls, plus one long hold-off once armed so
    // that a flush backs up into the input port.
    always @(posedge i_clk) begin
        if (hold_armed && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every pulse transaction is checked against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            frames.match_pulse(o_pulse, o_last);
        end
    end

    // One input transaction. Called at a rising edge; returns at the edge
    // where the item was taken, valid still high so a back-to-back item can
    // follow without a bubble.
    task automatic push_item(input logic cmd, input logic [TIME_W-1:0] now,
                             input logic pin);
        int gap;
        gap = 0;
        while (gap < 100 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_now_us    <= now;
        i_pin_level <= pin;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (frames.capture_item(cmd, now, pin)) live_items++;
    endtask

    // One register write; more=1 keeps valid up for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        frames.set_reg(idx, data);
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] ex, input logic [CFG_DATA_W-1:0] to,
                            input logic [CFG_DATA_W-1:0] cap);
        write_reg(ipwc_pkg::REG_EXCESS, ex, 1'b1);
        write_reg(ipwc_pkg::REG_TIMEOUT, to, 1'b1);
        write_reg(ipwc_pkg::REG_CAPACITY, cap, 1'b0);
    endtask

    // Stop offering items, wait for every owed pulse, then let any edge
    // still in the front end settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (frames.pulses_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic: mostly whole frames (alternating edges, an occasional
    // early tick, then a tick past the timeout), some open frames left to
    // the next one, and some fully random transactions.
    task automatic run_phase(input int unsigned n);
        int unsigned target;
        int unsigned len;
        int unsigned delta;
        int unsigned margin;
        int unsigned gap;
        logic        level;
        target = live_items + n;
        while (live_items < target) begin
            if ($urandom_range(99) < 80) begin
                len   = ($urandom_range(9) == 0) ? $urandom_range(1, DEPTH + 2)
                                                 : $urandom_range(1, 10);
                level = 1'($urandom_range(1));
                for (int k = 0; k < len; k++) begin
                    delta = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(1, 20000);
                    push_item(CMD_EDGE, frames.prev_time + delta, level);
                    level = ~level;
                    if ($urandom_range(7) == 0) begin
                        gap = (frames.timeout == 0) ? 0 : $urandom_range(frames.timeout - 1);
                        push_item(CMD_TICK, frames.prev_time + gap, 1'($urandom_range(1)));
                    end
                end
                if ($urandom_range(9) != 0) begin
                    // a margin that would wrap past a huge timeout would miss it
                    margin = $urandom_range(40);
                    if (32'hFFFF_FFFF - frames.timeout < margin) margin = 0;
                    push_item(CMD_TICK, frames.prev_time + frames.timeout + margin,
                              1'($urandom_range(1)));
                end
            end else begin
                push_item(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        frames      = new();
        tx_idle_pct = 28;
        rx_idle_pct = 85;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Most negative excess, short timeout, capacity above the buffer
        // depth (saturates). The unused index must change nothing.
        write_reg(REG_SPARE, 32'hDEAD_BEEF, 1'b1);
        set_regs(32'h0000_8000, 32'd100, 32'd127);
        push_item(CMD_TICK, 32'd0, 1'b0);                               // idle tick
        push_item(CMD_EDGE, 32'hFFFF_FF00, 1'b0);                       // opens, stores nothing
        push_item(CMD_EDGE, frames.prev_time + 32'hFFFF_8000, 1'b1);    // mark wraps to zero
        push_item(CMD_EDGE, frames.prev_time + 32'hFFFF_FFFF, 1'b0);    // widest space
        push_item(CMD_TICK, frames.prev_time + 32'd99, 1'b1);           // one short of timeout
        push_item(CMD_TICK, frames.prev_time + 32'd100, 1'b0);          // flush

        // Overflow at capacity 2, then a raised capacity lifts it at the
        // next edge; longest possible timeout closes the frame.
        wait_drained();
        set_regs(32'h0000_7FFF, 32'hFFFF_FFFF, 32'd2);
        push_item(CMD_EDGE, frames.prev_time + 32'd1, 1'b1);
        push_item(CMD_EDGE, frames.prev_time + 32'd5, 1'b0);
        push_item(CMD_EDGE, frames.prev_time + 32'd7, 1'b1);
        push_item(CMD_EDGE, frames.prev_time + 32'd9, 1'b0);
        wait_drained();
        write_reg(ipwc_pkg::REG_CAPACITY, 32'd64, 1'b0);
        push_item(CMD_EDGE, frames.prev_time + 32'd11, 1'b0);
        push_item(CMD_EDGE, frames.prev_time + 32'd13, 1'b1);
        push_item(CMD_TICK, frames.prev_time + 32'hFFFF_FFFF, 1'b1);

        // Capacity zero: every edge overflows; zero timeout closes at once.
        wait_drained();
        write_reg(ipwc_pkg::REG_CAPACITY, 32'd0, 1'b1);
        write_reg(ipwc_pkg::REG_TIMEOUT, 32'd0, 1'b0);
        push_item(CMD_EDGE, frames.prev_time + 32'd40, 1'b0);
        push_item(CMD_EDGE, frames.prev_time, 1'b1);
        push_item(CMD_TICK, frames.prev_time, 1'b0);
        push_item(CMD_TICK, frames.prev_time, 1'b1);

        // Reset-value timeout, capacity 1; a frame with no stored entry
        // closes silently.
        wait_drained();
        set_regs(32'd0, ipwc_pkg::TIMEOUT_RST, 32'd1);
        push_item(CMD_EDGE, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_EDGE, frames.prev_time + 32'd300, 1'b1);
        push_item(CMD_TICK, frames.prev_time + 32'd20000, 1'b0);
        push_item(CMD_EDGE, frames.prev_time + 32'd5, 1'b1);
        push_item(CMD_TICK, frames.prev_time + 32'd20000, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph / 2)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 85;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (ph)
                0: set_regs($urandom_range(400) - 200, ipwc_pkg::TIMEOUT_RST, 32'd64);
                1: set_regs(32'h0000_8000, 32'd0, 32'd1);
                2: set_regs(32'h0000_7FFF, 32'hFFFF_FFFF, 32'd127);
                // junk above each register's width must be dropped
                3: set_regs($urandom(), $urandom_range(500, 100000), $urandom());
                4: set_regs($urandom_range(100), 32'd3000, $urandom_range(2, 12));
                default: set_regs($urandom(), $urandom_range(1, 50000), 32'd64);
            endcase
            // long receiver stall early in the first random phase
            if (ph == 0) hold_armed = 1'b1;
            run_phase(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frames.errors == 0) begin
            $display("ir_pulse_width_capture_top: match");
        end else begin
            $display("ir_pulse_width_capture_top: mismatch");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("ir_pulse_width_capture_top: mismatch");
        $finish;
    end

endmodule
